[rtl/bmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP parser package
// Shared types, codes and sizes for the 24-bit BMP stream parser.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NOT_BMP     = 3'd0,
    ERR_HEADER_TYPE = 3'd1,
    ERR_COMPRESSION = 3'd2,
    ERR_BPP         = 3'd3,
    ERR_TOO_LARGE   = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_PIXELS = 3'd2,
    PH_PAD    = 3'd3,
    PH_IGNORE = 3'd4
  } phase_e;

  // Result item: fields in output order
  typedef struct packed {
    logic        last_pixel;
    logic [12:0] image_height;
    logic [12:0] image_width;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
    logic [2:0]  error_code;
    logic [1:0]  kind;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

[rtl/bmp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP parser front
// Accepts bytes, walks the header and pixel phases, and forms one result per
// item that produces one; results go to the queue.
// ----------------------------------------------------------------------------
module bmp_front #(
  parameter int unsigned MAX_WIDTH  = bmp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmp_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              file_start_i,
  input  logic              q_full_i,
  output logic              in_ready_o,
  output logic              res_valid_o,
  output bmp_pkg::result_t  res_o
);
  import bmp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [5:0]  idx_q, idx_d;
  logic        info_q, info_d;
  logic [31:0] acc_q, acc_d;
  logic        magic_q, magic_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] bpp_q, bpp_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [1:0]  chan_q, chan_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;
  logic [1:0]  pad_q, pad_d;
  // precomputed bounds, refreshed after header (sequenced registers)
  logic [15:0] wlast_q, hlast_q;

  logic        fire;
  result_t     res;
  logic        emit;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    phase_e     ph;
    logic [5:0] idx;
    logic [31:0] acc_new;
    logic [5:0] k;
    phase_d  = phase_q;
    idx_d    = idx_q;
    info_d   = info_q;
    acc_d    = acc_q;
    magic_d  = magic_q;
    width_d  = width_q;
    height_d = height_q;
    bpp_d    = bpp_q;
    col_d    = col_q;
    row_d    = row_q;
    chan_d   = chan_q;
    blue_d   = blue_q;
    green_d  = green_q;
    pad_d    = pad_q;
    res      = '0;
    emit     = 1'b0;
    ph       = phase_q;
    idx      = idx_q;
    acc_new  = acc_q;
    k        = '0;
    if (file_start_i) begin
      ph = PH_HEADER; idx = '0; info_d = 1'b0; acc_new = '0; magic_d = 1'b0;
      width_d = '0; height_d = '0; bpp_d = '0;
    end
    phase_d = ph;
    // little-endian byte lane in the current field
    if (idx >= 6'd14 && idx < 6'd18) k = idx - 6'd14;
    else if (idx >= 6'd30 && idx < 6'd34) k = idx - 6'd30;
    else if (!(file_start_i ? 1'b0 : info_q) && idx >= 6'd18) k = {5'd0, idx[0]};
    else if (idx >= 6'd18 && idx < 6'd22) k = idx - 6'd18;
    else if (idx >= 6'd22 && idx < 6'd26) k = idx - 6'd22;
    else if (idx >= 6'd28) k = {5'd0, idx[0]};
    case (k[1:0])
      2'd0:    acc_new = {24'd0, data_byte_i};
      2'd1:    acc_new = {acc_q[31:16], data_byte_i, acc_q[7:0]};
      2'd2:    acc_new = {acc_q[31:24], data_byte_i, acc_q[15:0]};
      default: acc_new = {data_byte_i, acc_q[23:0]};
    endcase
    case (ph)
      PH_HEADER: begin
        logic inf;
        logic fin;
        inf = file_start_i ? 1'b0 : info_q;
        fin = 1'b0;
        if (idx < 6'd63) idx_d = idx + 6'd1; else idx_d = idx;
        if (idx == 6'd0) magic_d = (data_byte_i == 8'h42);
        else if (idx == 6'd1) magic_d = magic_q && (data_byte_i == 8'h4D);
        else if (idx == 6'd13) begin
          if (!magic_q) begin
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NOT_BMP;
            phase_d = PH_IGNORE;
          end
        end else if (idx >= 6'd14 && idx < 6'd18) begin
          acc_d = acc_new;
          if (idx == 6'd17) begin
            if (acc_new == 32'd12) info_d = 1'b0;
            else if (acc_new == 32'd40) info_d = 1'b1;
            else begin
              emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_HEADER_TYPE;
              phase_d = PH_IGNORE;
            end
          end
        end else if (idx >= 6'd18) begin
          if (!inf) begin
            if (idx < 6'd22 || (idx >= 6'd24 && idx < 6'd26)) acc_d = acc_new;
            if (idx == 6'd19) width_d  = acc_new;
            if (idx == 6'd21) height_d = acc_new;
            if (idx == 6'd25) begin bpp_d = acc_new[15:0]; fin = 1'b1; end
          end else begin
            if (idx < 6'd26 || (idx >= 6'd28 && idx < 6'd34)) acc_d = acc_new;
            if (idx == 6'd21) width_d  = acc_new;
            if (idx == 6'd25) height_d = acc_new;
            if (idx == 6'd29) bpp_d    = acc_new[15:0];
            if (idx == 6'd33 && acc_new != 32'd0) begin
              emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_COMPRESSION;
              phase_d = PH_IGNORE;
            end
            if (idx == 6'd53) fin = 1'b1;
          end
          if (fin) begin
            emit = 1'b1;
            if (bpp_d != 16'd24) begin
              res.kind = KIND_ERROR; res.error_code = ERR_BPP; phase_d = PH_IGNORE;
            end else if (width_d > MAX_WIDTH || height_d > MAX_HEIGHT) begin
              res.kind = KIND_ERROR; res.error_code = ERR_TOO_LARGE; phase_d = PH_IGNORE;
            end else begin
              res.kind = KIND_HEADER;
              res.image_width  = width_d[12:0];
              res.image_height = height_d[12:0];
              col_d = '0; row_d = '0; chan_d = '0;
              phase_d = (width_d != 0 && height_d != 0) ? PH_PIXELS : PH_IGNORE;
            end
          end
        end
      end
      PH_PIXELS: begin
        case (chan_q)
          2'd0: begin blue_d = data_byte_i; chan_d = 2'd1; end
          2'd1: begin green_d = data_byte_i; chan_d = 2'd2; end
          default: begin
            logic last;
            logic eol;
            logic [15:0] ydiff;
            chan_d = 2'd0;
            eol  = (col_q == wlast_q);
            last = (row_q == hlast_q) && eol;
            ydiff = hlast_q - row_q;
            emit = 1'b1;
            res.kind    = KIND_PIXEL;
            res.pixel_x = col_q[11:0];
            res.pixel_y = ydiff[11:0];
            res.red     = data_byte_i;
            res.green   = green_q;
            res.blue    = blue_q;
            res.last_pixel = last;
            col_d = col_q + 16'd1;
            if (last) phase_d = PH_IGNORE;
            else if (eol) begin
              col_d = '0;
              row_d = row_q + 16'd1;
              pad_d = width_q[1:0];
              if (width_q[1:0] != 2'd0) phase_d = PH_PAD;
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_d = pad_q - 2'd1;
        if (pad_q <= 2'd1) begin pad_d = '0; phase_d = PH_PIXELS; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT; idx_q <= '0; info_q <= 1'b0; acc_q <= '0; magic_q <= 1'b0;
      width_q <= '0; height_q <= '0; bpp_q <= '0; col_q <= '0; row_q <= '0;
      chan_q <= '0; blue_q <= '0; green_q <= '0; pad_q <= '0;
      wlast_q <= '0; hlast_q <= '0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; idx_q <= idx_d; info_q <= info_d; acc_q <= acc_d;
        magic_q <= magic_d; width_q <= width_d; height_q <= height_d; bpp_q <= bpp_d;
        col_q <= col_d; row_q <= row_d; chan_q <= chan_d; blue_q <= blue_d;
        green_q <= green_d; pad_q <= pad_d;
      end
      // accepted dimensions fit 16 bits; header ends well before pixels
      wlast_q <= width_q[15:0] - 16'd1;
      hlast_q <= height_q[15:0] - 16'd1;
    end
  end

  assign res_valid_o = fire && emit;
  assign res_o       = res;

endmodule

[rtl/bmp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP result queue
// Two-entry queue between the parse front and the output port.
// ----------------------------------------------------------------------------
module bmp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  bmp_pkg::result_t  wr_data_i,
  output logic              full_o,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output bmp_pkg::result_t  rd_data_o
);
  import bmp_pkg::*;

  result_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o     = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !full_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[rtl/bmp_rgb24_stream_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP 24-bit stream parser
// Parses an uncompressed 24 bpp BMP file delivered one byte per item.
// ----------------------------------------------------------------------------
// Slave channel: one file byte per item, tuser high on the first byte of a
// file. Master channel: one result per producing item - header accepted,
// error, or a pixel per B,G,R triplet with row 0 at the top.
// One byte is taken every cycle while the two-entry result queue has room;
// a result enters the queue as the byte that makes it is taken. The queue is
// what sets the rate: a stalled receiver fills it, and s_axis_tready drops
// until an item is taken. Padding bytes and most header bytes make no result.
// After reset the parser waits for a byte with tuser set, ignoring others; an
// error, the last pixel or an empty image likewise parks it until the next file.
// ----------------------------------------------------------------------------
module bmp_rgb24_stream_parser #(
  parameter int unsigned MAX_WIDTH  = bmp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmp_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // file_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // error_code[2:0], pixel_x[14:3],
                                        // pixel_y[26:15], red[34:27],
                                        // green[42:35], blue[50:43],
                                        // image_width[63:51],
                                        // image_height[76:64]
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // last_pixel
);
  import bmp_pkg::*;

  result_t res, qout;
  logic    res_valid, q_full;

  bmp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid_i),
    .data_byte_i  (s_axis_tdata_i),
    .file_start_i (s_axis_tuser_i),
    .q_full_i     (q_full),
    .in_ready_o   (s_axis_tready_o),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  bmp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (res_valid),
    .wr_data_i  (res),
    .full_o     (q_full),
    .rd_valid_o (m_axis_tvalid_o),
    .rd_ready_i (m_axis_tready_i),
    .rd_data_o  (qout)
  );

  assign m_axis_tuser_o = qout.kind;
  assign m_axis_tlast_o = qout.last_pixel;
  assign m_axis_tdata_o = {3'd0, qout.image_height, qout.image_width, qout.blue,
                           qout.green, qout.red, qout.pixel_y, qout.pixel_x,
                           qout.error_code};

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream parser testbench
// Feeds BMP files byte by byte (good images, broken headers and noise) and
// compares every header, error and pixel item against a local parse model.
// ----------------------------------------------------------------------------
module testbench;
  import bmp_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [12:0] w;
    logic [12:0] h;
    logic        last;
  } parse_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  bmp_rgb24_stream_parser uut (.*);

  always #5 clk_i = ~clk_i;

  byte_item_t  pending_bytes[$];
  parse_out_t  expected_out[$];
  int unsigned idle_pct = 0, stall_pct = 0;
  bit          hold_off = 1'b0;
  bit          hold_go = 1'b0;
  bit          failed = 1'b0;
  int unsigned watch_cnt = 0;
  int unsigned n_pixels = 0, n_headers = 0, n_errors = 0, n_files = 0;

  // Parse model state
  phase_e      ph = PH_WAIT;
  int unsigned hidx, acc, bw, bh, bpp, col, rw, chan, pad;
  bit          info, magic_ok;
  logic [7:0]  hb, hg;

  function automatic bit take_field(int unsigned idx, logic [7:0] v, int unsigned s,
                                    int unsigned n);
    if (idx < s || idx >= s + n) return 1'b0;
    if (idx == s) acc = v;
    else acc |= 32'(v) << (8 * (idx - s));
    return idx == s + n - 1;
  endfunction

  function automatic bit raise_error(err_e c, output parse_out_t o);
    o = '0;
    o.kind = KIND_ERROR;
    o.code = c;
    ph = PH_IGNORE;
    return 1'b1;
  endfunction

  function automatic bit close_header(output parse_out_t o);
    o = '0;
    if (bpp != 24) return raise_error(ERR_BPP, o);
    if (bw > uut.MAX_WIDTH || bh > uut.MAX_HEIGHT) return raise_error(ERR_TOO_LARGE, o);
    o.kind = KIND_HEADER;
    o.w = bw[12:0];
    o.h = bh[12:0];
    col = 0; rw = 0; chan = 0;
    ph = (bw != 0 && bh != 0) ? PH_PIXELS : PH_IGNORE;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(byte_item_t it, output parse_out_t o);
    int unsigned idx;
    bit          lst;
    o = '0;
    if (it.start) begin
      ph = PH_HEADER; hidx = 0; info = 0; acc = 0; magic_ok = 0;
      bw = 0; bh = 0; bpp = 0;
    end
    case (ph)
      PH_HEADER: begin
        idx = hidx;
        if (hidx < 63) hidx++;
        if (idx == 0) begin magic_ok = (it.data == 8'h42); return 0; end
        if (idx == 1) begin magic_ok = magic_ok && (it.data == 8'h4D); return 0; end
        if (idx < 13) return 0;
        if (idx == 13) return magic_ok ? 1'b0 : raise_error(ERR_NOT_BMP, o);
        if (take_field(idx, it.data, 14, 4)) begin
          if (acc == 12) info = 0;
          else if (acc == 40) info = 1;
          else return raise_error(ERR_HEADER_TYPE, o);
          return 0;
        end
        if (idx < 18) return 0;
        if (!info) begin
          if (take_field(idx, it.data, 18, 2)) bw = acc;
          if (take_field(idx, it.data, 20, 2)) bh = acc;
          if (take_field(idx, it.data, 24, 2)) begin
            bpp = acc;
            return close_header(o);
          end
          return 0;
        end
        if (take_field(idx, it.data, 18, 4)) bw = acc;
        if (take_field(idx, it.data, 22, 4)) bh = acc;
        if (take_field(idx, it.data, 28, 2)) bpp = acc;
        if (take_field(idx, it.data, 30, 4) && acc != 0) return raise_error(ERR_COMPRESSION, o);
        if (idx == 53) return close_header(o);
        return 0;
      end
      PH_PIXELS: begin
        if (chan == 0) begin hb = it.data; chan = 1; return 0; end
        if (chan == 1) begin hg = it.data; chan = 2; return 0; end
        chan = 0;
        lst = (rw == bh - 1) && (col == bw - 1);
        o.kind = KIND_PIXEL;
        o.px = col[11:0];
        o.py = 12'(bh - 1 - rw);
        o.r = it.data; o.g = hg; o.b = hb;
        o.last = lst;
        col++;
        if (lst) ph = PH_IGNORE;
        else if (col >= bw) begin
          col = 0; rw++;
          pad = bw & 3;
          if (pad != 0) ph = PH_PAD;
        end
        return 1;
      end
      PH_PAD: begin
        if (pad > 0) pad--;
        if (pad == 0) ph = PH_PIXELS;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // Driver: offer the head of the queue, advance on acceptance
  always @(posedge clk_i) begin
    parse_out_t o;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      if (parse_byte(pending_bytes.pop_front(), o)) expected_out.push_back(o);
    end
    if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
      // queue head after a possible pop
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= pending_bytes[0].data;
      s_axis_tuser_i  <= pending_bytes[0].start;
    end else if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom();
      s_axis_tuser_i  <= $urandom();
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    parse_out_t a, e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      a.kind = m_axis_tuser_o;
      a.code = m_axis_tdata_o[2:0];
      a.px = m_axis_tdata_o[14:3];
      a.py = m_axis_tdata_o[26:15];
      a.r = m_axis_tdata_o[34:27];
      a.g = m_axis_tdata_o[42:35];
      a.b = m_axis_tdata_o[50:43];
      a.w = m_axis_tdata_o[63:51];
      a.h = m_axis_tdata_o[76:64];
      a.last = m_axis_tlast_o;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %p", $time, a);
        failed = 1'b1;
      end else begin
        e = expected_out.pop_front();
        if (a !== e) begin
          $display("%0t: item mismatch, expected %p, actual %p", $time, e, a);
          failed = 1'b1;
        end
        case (e.kind)
          KIND_PIXEL: n_pixels++;
          KIND_HEADER: n_headers++;
          default: n_errors++;
        endcase
      end
    end
    m_axis_tready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Receiver hold-off: count the stretch here while the sender keeps going
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || hold_off)
      watch_cnt <= 0;
    else if (rst_ni) begin
      watch_cnt <= watch_cnt + 1;
      if (watch_cnt >= WatchLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_le(int unsigned v, int unsigned n);
    for (int i = 0; i < n; i++) pending_bytes.push_back('{1'b0, 8'(v >> (8 * i))});
  endtask

  // Build one file; extra adds trailing bytes after the pixel array
  task automatic queue_file(bit info_hdr, int unsigned w, int unsigned h, int unsigned bits,
                            int unsigned comp, int unsigned hsize, bit bad_magic,
                            int extra);
    int unsigned nbytes;
    pending_bytes.push_back('{1'b1, bad_magic ? 8'($urandom_range(255)) : 8'h42});
    pending_bytes.push_back('{1'b0, bad_magic ? 8'h00 : 8'h4D});
    push_le($urandom(), 4); push_le($urandom(), 4); push_le(54, 4);
    push_le(hsize, 4);
    if (!info_hdr) begin
      push_le(w, 2); push_le(h, 2); push_le(1, 2); push_le(bits, 2);
    end else begin
      push_le(w, 4); push_le(h, 4); push_le(1, 2); push_le(bits, 2); push_le(comp, 4);
      for (int i = 0; i < 20; i++) pending_bytes.push_back('{1'b0, 8'($urandom())});
    end
    nbytes = ((3 * w + 3) & ~3) * h;
    if (w > 8 || h > 8) nbytes = 4;  // oversize or wide: only a few bytes follow
    for (int i = 0; i < int'(nbytes) + extra; i++)
      pending_bytes.push_back('{1'b0, 8'($urandom())});
    n_files++;
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || expected_out.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sel, fed, base;
    bit          rinf;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: noise before any file, each error, both header kinds, empty image
    for (int i = 0; i < 4; i++) pending_bytes.push_back('{1'b0, 8'($urandom())});
    queue_file(0, 1, 1, 24, 0, 12, 1, 0);
    queue_file(0, 1, 1, 24, 0, 13, 0, 0);
    queue_file(1, 1, 1, 24, 5, 40, 0, 0);
    queue_file(0, 1, 1, 32, 0, 12, 0, 0);
    queue_file(0, 4097, 1, 24, 0, 12, 0, 0);
    queue_file(1, 1, 32'hFFFF_FFFF, 24, 0, 40, 0, 0);
    queue_file(0, 4096, 4096, 24, 0, 12, 0, 0);
    queue_file(0, 0, 3, 24, 0, 12, 0, 4);
    queue_file(0, 3, 2, 24, 0, 12, 0, 5);
    queue_file(1, 2, 2, 24, 0, 40, 0, 0);
    pending_bytes.push_back('{1'b1, 8'hFF});
    push_le(0, 3);
    drain();
    for (int phs = 0; phs < 4; phs++) begin
      idle_pct  = (phs == 1 || phs == 3) ? (phs == 3 ? 34 : 71) : 0;
      stall_pct = (phs == 2 || phs == 3) ? (phs == 3 ? 34 : 71) : 0;
      fed = 0;
      while (fed < 40) begin
        sel = $urandom_range(9);
        base = pending_bytes.size();
        if (sel < 7) begin
          rinf = $urandom_range(1);
          queue_file(rinf, $urandom_range(1, 5), $urandom_range(1, 3), 24, 0,
                     rinf ? 40 : 12, 0, $urandom_range(0, 3));
        end else if (sel == 7)
          queue_file(1, $urandom_range(6), $urandom_range(3), $urandom_range(1) ? 24 : 16,
                     $urandom_range(1), 40, $urandom_range(3) == 0, 0);
        else
          for (int i = 0; i < 8; i++)
            pending_bytes.push_back('{1'($urandom()), 8'($urandom())});
        fed += pending_bytes.size() - base;
        while (pending_bytes.size() > 40) @(posedge clk_i);
      end
      if (phs == 0) begin
        // long receiver hold-off while bytes keep coming
        hold_go = 1'b1;
        queue_file(0, 3, 3, 24, 0, 12, 0, 0);
        @(posedge clk_i);
        wait (!hold_off);
      end
      drain();
    end
    $display("Ran %0d files: %0d headers, %0d errors, %0d pixels checked.",
             n_files, n_headers, n_errors, n_pixels);
    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[bmp_rgb24_stream_parser.f]
rtl/bmp_pkg.sv
rtl/bmp_front.sv
rtl/bmp_queue.sv
rtl/bmp_rgb24_stream_parser.sv
tb/testbench.sv
